// ----- design/pidaw_pkg.sv -----
// shared types, constants and control structs of the pid anti-windup controller
package pidaw_pkg;

   localparam int DATA_W    = 32;
   localparam int ACC_W     = 48;
   localparam int FRAC_W    = 16;
   localparam int CHUNK_W   = 16;
   localparam int PROD_W    = DATA_W + ACC_W;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] PIDAW_INIT_ERROR = 32'sh0000_0000;

   localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;
   localparam logic signed [ACC_W-1:0]  MAX48 = 48'sh7fff_ffff_ffff;
   localparam logic signed [ACC_W-1:0]  MIN48 = 48'sh8000_0000_0000;

   localparam logic signed [DATA_W-1:0] RST_GAIN     = 32'sh0000_0000;
   localparam logic signed [DATA_W-1:0] RST_LIMIT_LO = 32'shffff_0000;
   localparam logic signed [DATA_W-1:0] RST_LIMIT_HI = 32'sh0001_0000;
   localparam logic [DATA_W-1:0]        RST_DT_FLOOR = 32'h0000_0001;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_OUT_MIN    = 3'd3,
      CSR_OUT_MAX    = 3'd4,
      CSR_WINDOW_MIN = 3'd5,
      CSR_WINDOW_MAX = 3'd6,
      CSR_DT_FLOOR   = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_LOW  = 2'd1,
      CLAMP_HIGH = 2'd2
   } clamp_type;

   typedef enum logic [2:0] {
      MSEL_INT   = 3'd0,
      MSEL_P     = 3'd1,
      MSEL_I     = 3'd2,
      MSEL_D     = 3'd3,
      MSEL_ITERM = 3'd4
   } mul_sel_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] measurement;
      logic [DATA_W-1:0]        step_time;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] control_out;
      logic signed [DATA_W-1:0] error_now;
      logic signed [ACC_W-1:0]  integral_sum;
      logic signed [DATA_W-1:0] derivative_rate;
      logic signed [DATA_W-1:0] p_term;
      logic signed [DATA_W-1:0] i_term;
      logic signed [DATA_W-1:0] d_term;
      logic [1:0]               clamp_state;
   } rsp_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        cap_pred;
      logic        cap_p;
      logic        cap_ipred;
      logic        cap_rate;
      logic        cap_d;
      logic        decide;
      logic        push;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
      logic rsp_full;
   } status_type;

endpackage

// ----- design/pidaw_mul.sv -----
// shared 32 x 48 unsigned multiplier, one 16-bit chunk per cycle, with q16.16 saturation
module pidaw_mul import pidaw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DATA_W-1:0]        a,
   input  logic [ACC_W-1:0]         b,
   input  logic                     neg,
   output logic                     busy,
   output logic [PROD_W-1:0]        prod,
   output logic signed [DATA_W-1:0] q16
);

   localparam int NCHUNK = ACC_W / CHUNK_W;
   localparam int CNT_W  = $clog2(NCHUNK);
   localparam int PP_W   = DATA_W + CHUNK_W;
   localparam int M_W    = PROD_W - FRAC_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCHUNK - 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DATA_W-1:0]   a_ff;
   logic [ACC_W-1:0]    b_ff, b_in;
   logic                neg_ff;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [CHUNK_W-1:0]  chunk;
   logic [PP_W-1:0]     pp;
   logic [M_W-1:0]      m;
   logic                hi_nz;

   // most significant chunk first, accumulator shifts up each step
   assign chunk  = b_ff[ACC_W-1 -: CHUNK_W];
   assign pp     = PP_W'(a_ff) * PP_W'(chunk);
   assign acc_in = {acc_ff[PROD_W-CHUNK_W-1:0], CHUNK_W'(0)} + PROD_W'(pp);
   assign b_in   = {b_ff[ACC_W-CHUNK_W-1:0], CHUNK_W'(0)};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         neg_ff <= neg;
         acc_ff <= '0;
      end else if (busy_ff) begin
         b_ff   <= b_in;
         acc_ff <= acc_in;
      end
   end

   assign m     = acc_ff[PROD_W-1:FRAC_W];
   assign hi_nz = |m[M_W-1:DATA_W];

   always_comb begin
      if (neg_ff) begin
         if (hi_nz || (m[DATA_W-1] && (|m[DATA_W-2:0]))) begin
            q16 = MIN32;
         end else begin
            q16 = -signed'(m[DATA_W-1:0]);
         end
      end else begin
         if (hi_nz || m[DATA_W-1]) begin
            q16 = MAX32;
         end else begin
            q16 = signed'(m[DATA_W-1:0]);
         end
      end
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

// ----- design/pidaw_div.sv -----
// restoring divider for the derivative, one quotient bit per cycle, saturating
module pidaw_div import pidaw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W:0]   diff,
   input  logic [DATA_W-1:0]        divisor,
   output logic                     busy,
   output logic signed [DATA_W-1:0] rate
);

   localparam int CNT_W = $clog2(DATA_W);
   localparam int HI_W  = DATA_W + 1 - FRAC_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DATA_W:0]     dmag;
   logic [HI_W-1:0]     hi;
   logic                zero;
   logic                ovf;
   logic                neg_ff;
   logic                ovf_ff;
   logic [DATA_W-1:0]   dvs_ff;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   low_ff;
   logic [DATA_W-1:0]   quo_ff;
   logic [DATA_W:0]     rem2;
   logic [DATA_W:0]     rem_sub;
   logic                ge;

   assign dmag = diff[DATA_W] ? unsigned'(-diff) : unsigned'(diff);
   assign hi   = dmag[DATA_W:FRAC_W];
   assign zero = (dmag == '0);
   // quotient of 2^32 or more saturates either way, a zero divisor lands here too
   assign ovf  = !zero && (DATA_W'(hi) >= divisor);

   assign rem2    = {rem_ff, low_ff[DATA_W-1]};
   assign ge      = (rem2 >= {1'b0, dvs_ff});
   assign rem_sub = rem2 - {1'b0, dvs_ff};
   assign rem_in  = ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = !zero && !ovf;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= diff[DATA_W];
         ovf_ff <= ovf;
         dvs_ff <= divisor;
         rem_ff <= DATA_W'(hi);
         low_ff <= {dmag[FRAC_W-1:0], FRAC_W'(0)};
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[DATA_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DATA_W-2:0], ge};
      end
   end

   always_comb begin
      if (ovf_ff) begin
         rate = neg_ff ? MIN32 : MAX32;
      end else if (neg_ff) begin
         if (quo_ff[DATA_W-1] && (|quo_ff[DATA_W-2:0])) begin
            rate = MIN32;
         end else begin
            rate = -signed'(quo_ff);
         end
      end else begin
         rate = quo_ff[DATA_W-1] ? MAX32 : signed'(quo_ff);
      end
   end

   assign busy = busy_ff;

endmodule

// ----- design/pidaw_dp.sv -----
// datapath: control registers, loop state, term registers and result register
module pidaw_dp import pidaw_pkg::*; #(
   parameter logic signed [DATA_W-1:0] INIT_ERROR = PIDAW_INIT_ERROR
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           st,
   input  req_type              req_data,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   logic signed [DATA_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [DATA_W-1:0] out_min_ff, out_max_ff, win_min_ff, win_max_ff;
   logic [DATA_W-1:0]        dt_floor_ff;

   logic signed [DATA_W-1:0] last_err_ff, last_err_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0]        dt_ff;
   logic                     sum_neg_ff;
   logic signed [ACC_W-1:0]  pred_ff, pred_in;
   logic signed [DATA_W-1:0] p_ff, ipred_ff, d_ff, rate_ff;
   logic signed [DATA_W-1:0] ctl_ff, ctl_in;
   clamp_type                clamp_ff, clamp_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic signed [DATA_W:0]   err_wide;
   logic signed [DATA_W:0]   diff;
   logic signed [DATA_W:0]   sum;
   logic [DATA_W:0]          sum_mag;
   logic [DATA_W-1:0]        divisor;

   logic [DATA_W-1:0]        mul_a;
   logic [ACC_W-1:0]         mul_b;
   logic                     mul_neg;
   logic                     mul_busy;
   logic [PROD_W-1:0]        mul_prod;
   logic signed [DATA_W-1:0] mul_q16;

   logic                     div_busy;
   logic signed [DATA_W-1:0] div_rate;

   logic [ACC_W-2:0]         inc_mag;
   logic signed [ACC_W:0]    delta;
   logic signed [ACC_W:0]    pred_wide;
   logic signed [DATA_W+1:0] total;
   logic                     in_window;

   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
      mag32 = v[DATA_W-1] ? unsigned'(-v) : unsigned'(v);
   endfunction

   function automatic logic [ACC_W-1:0] mag48(input logic signed [ACC_W-1:0] v);
      mag48 = v[ACC_W-1] ? unsigned'(-v) : unsigned'(v);
   endfunction

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= RST_GAIN;
         gain_i_ff   <= RST_GAIN;
         gain_d_ff   <= RST_GAIN;
         out_min_ff  <= RST_LIMIT_LO;
         out_max_ff  <= RST_LIMIT_HI;
         win_min_ff  <= RST_LIMIT_LO;
         win_max_ff  <= RST_LIMIT_HI;
         dt_floor_ff <= RST_DT_FLOOR;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_GAIN_P:     gain_p_ff   <= signed'(csr_data);
            CSR_GAIN_I:     gain_i_ff   <= signed'(csr_data);
            CSR_GAIN_D:     gain_d_ff   <= signed'(csr_data);
            CSR_OUT_MIN:    out_min_ff  <= signed'(csr_data);
            CSR_OUT_MAX:    out_max_ff  <= signed'(csr_data);
            CSR_WINDOW_MIN: win_min_ff  <= signed'(csr_data);
            CSR_WINDOW_MAX: win_max_ff  <= signed'(csr_data);
            CSR_DT_FLOOR:   dt_floor_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // error of the new request
   assign err_wide = (DATA_W+1)'(req_data.setpoint) - (DATA_W+1)'(req_data.measurement);

   always_comb begin
      if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
         cur_in = err_wide[DATA_W] ? MIN32 : MAX32;
      end else begin
         cur_in = err_wide[DATA_W-1:0];
      end
   end

   assign diff    = (DATA_W+1)'(cur_ff) - (DATA_W+1)'(last_err_ff);
   assign sum     = (DATA_W+1)'(cur_ff) + (DATA_W+1)'(last_err_ff);
   assign sum_mag = sum[DATA_W] ? unsigned'(-sum) : unsigned'(sum);
   assign divisor = (dt_ff < dt_floor_ff) ? dt_floor_ff : dt_ff;

   // multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MSEL_INT: begin
            mul_a   = dt_ff;
            mul_b   = ACC_W'(sum_mag);
            mul_neg = 1'b0;
         end
         MSEL_P: begin
            mul_a   = mag32(gain_p_ff);
            mul_b   = ACC_W'(mag32(cur_ff));
            mul_neg = gain_p_ff[DATA_W-1] ^ cur_ff[DATA_W-1];
         end
         MSEL_I: begin
            mul_a   = mag32(gain_i_ff);
            mul_b   = mag48(pred_ff);
            mul_neg = gain_i_ff[DATA_W-1] ^ pred_ff[ACC_W-1];
         end
         MSEL_D: begin
            mul_a   = mag32(gain_d_ff);
            mul_b   = ACC_W'(mag32(div_rate));
            mul_neg = gain_d_ff[DATA_W-1] ^ div_rate[DATA_W-1];
         end
         MSEL_ITERM: begin
            mul_a   = mag32(gain_i_ff);
            mul_b   = mag48(acc_ff);
            mul_neg = gain_i_ff[DATA_W-1] ^ acc_ff[ACC_W-1];
         end
         default: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   pidaw_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .neg   (mul_neg),
      .busy  (mul_busy),
      .prod  (mul_prod),
      .q16   (mul_q16)
   );

   pidaw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.prep),
      .diff    (diff),
      .divisor (divisor),
      .busy    (div_busy),
      .rate    (div_rate)
   );

   // trapezoidal increment is dt * |sum| / 2^17
   assign inc_mag   = mul_prod[ACC_W+FRAC_W-1:FRAC_W+1];
   assign delta     = sum_neg_ff ? -signed'({2'b00, inc_mag}) : signed'({2'b00, inc_mag});
   assign pred_wide = (ACC_W+1)'(acc_ff) + delta;

   always_comb begin
      if (pred_wide[ACC_W] != pred_wide[ACC_W-1]) begin
         pred_in = pred_wide[ACC_W] ? MIN48 : MAX48;
      end else begin
         pred_in = pred_wide[ACC_W-1:0];
      end
   end

   // output limits, then window test for the integral
   assign total     = (DATA_W+2)'(p_ff) + (DATA_W+2)'(ipred_ff) + (DATA_W+2)'(d_ff);
   assign in_window = (win_min_ff < ipred_ff) && (ipred_ff < win_max_ff);

   always_comb begin
      acc_in      = acc_ff;
      last_err_in = last_err_ff;
      ctl_in      = ctl_ff;
      clamp_in    = clamp_ff;
      if (cmd.decide) begin
         last_err_in = cur_ff;
         if (total <= (DATA_W+2)'(out_min_ff)) begin
            ctl_in   = out_min_ff;
            clamp_in = CLAMP_LOW;
         end else if (total >= (DATA_W+2)'(out_max_ff)) begin
            ctl_in   = out_max_ff;
            clamp_in = CLAMP_HIGH;
         end else begin
            ctl_in   = total[DATA_W-1:0];
            clamp_in = CLAMP_NONE;
            if (in_window) begin
               acc_in = pred_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= INIT_ERROR;
         acc_ff      <= ACC_W'(INIT_ERROR);
      end else begin
         last_err_ff <= last_err_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff   <= ctl_in;
      clamp_ff <= clamp_in;
      if (cmd.load) begin
         cur_ff <= cur_in;
         dt_ff  <= req_data.step_time;
      end
      if (cmd.prep) begin
         sum_neg_ff <= sum[DATA_W];
      end
      if (cmd.cap_pred) begin
         pred_ff <= pred_in;
      end
      if (cmd.cap_p) begin
         p_ff <= mul_q16;
      end
      if (cmd.cap_ipred) begin
         ipred_ff <= mul_q16;
      end
      if (cmd.cap_rate) begin
         rate_ff <= div_rate;
      end
      if (cmd.cap_d) begin
         d_ff <= mul_q16;
      end
   end

   // result register
   always_comb begin
      rsp_data_in.control_out     = ctl_ff;
      rsp_data_in.error_now       = cur_ff;
      rsp_data_in.integral_sum    = acc_ff;
      rsp_data_in.derivative_rate = rate_ff;
      rsp_data_in.p_term          = p_ff;
      rsp_data_in.i_term          = mul_q16;
      rsp_data_in.d_term          = d_ff;
      rsp_data_in.clamp_state     = clamp_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign st.mul_busy = mul_busy;
   assign st.div_busy = div_busy;
   assign st.rsp_full = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // never overwrite a result that is still waiting
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result pushed over a pending result");

   // the shared multiplier is never restarted mid-product
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   // the decision step sees finished terms only
   a_decide_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> (!mul_busy && !div_busy))
      else $error("decision taken with a unit still busy");

   // the i term shown is a finished product
   a_push_prod: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!mul_busy && !$past(cmd.mul_start)))
      else $error("result pushed before the i term product finished");

endmodule

// ----- design/pidaw_ctrl.sv -----
// sequencer that steps the datapath through one request
module pidaw_ctrl import pidaw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_PREP   = 10'b00_0000_0010,
      S_W_INT  = 10'b00_0000_0100,
      S_W_P    = 10'b00_0000_1000,
      S_W_I    = 10'b00_0001_0000,
      S_W_DIV  = 10'b00_0010_0000,
      S_W_D    = 10'b00_0100_0000,
      S_DECIDE = 10'b00_1000_0000,
      S_IT_GO  = 10'b01_0000_0000,
      S_W_IT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep      = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_INT;
            state_in      = S_W_INT;
         end
         S_W_INT: begin
            if (!st.mul_busy) begin
               cmd.cap_pred  = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_P;
               state_in      = S_W_P;
            end
         end
         S_W_P: begin
            cmd.mul_sel = MSEL_I;
            if (!st.mul_busy) begin
               cmd.cap_p     = 1'b1;
               cmd.mul_start = 1'b1;
               state_in      = S_W_I;
            end
         end
         S_W_I: begin
            cmd.mul_sel = MSEL_I;
            if (!st.mul_busy) begin
               cmd.cap_ipred = 1'b1;
               state_in      = S_W_DIV;
            end
         end
         S_W_DIV: begin
            cmd.mul_sel = MSEL_D;
            if (!st.div_busy) begin
               cmd.cap_rate  = 1'b1;
               cmd.mul_start = 1'b1;
               state_in      = S_W_D;
            end
         end
         S_W_D: begin
            cmd.mul_sel = MSEL_D;
            if (!st.mul_busy) begin
               cmd.cap_d = 1'b1;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_IT_GO;
         end
         S_IT_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_ITERM;
            state_in      = S_W_IT;
         end
         S_W_IT: begin
            cmd.mul_sel = MSEL_ITERM;
            if (!st.mul_busy && !st.rsp_full) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/pid_antiwindup_controller.sv -----
// top level of the pid controller with clamping anti-windup
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (setpoint, measurement, step_time)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (control_out ... clamp_state)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// the time from one acceptance to the next is set by the 32-step divider for the derivative,
// followed by the d and i term passes of the shared multiplier; a derivative that saturates
// at once or is zero skips the divider steps.
// synchronous reset loads default registers and the initial error into both loop states.
// a result waits in the output register while the next request is already taken; the
// sequencer holds before its last step only when that register is still occupied.
module pid_antiwindup_controller import pidaw_pkg::*; #(
   parameter logic signed [DATA_W-1:0] INIT_ERROR = PIDAW_INIT_ERROR
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   pidaw_dp #(
      .INIT_ERROR (INIT_ERROR)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
